// ===== hdl/mwm_pkg.sv =====
// Shared types, register indexes and the radix-16 divide step for the
// mecanum wheel speed mixer. No dependencies.
package mwm_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_SCALE = 2'd0,
    REG_TURN_RADIUS = 2'd1,
    REG_MAX_SPEED   = 2'd2
  } mwm_reg_t;

  localparam logic [15:0] WHEEL_SCALE_RST = 16'd2381;
  localparam logic [15:0] ROT_RADIUS_RST  = 16'd19661;
  localparam logic [14:0] MAX_SPEED_RST   = 15'd12288;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] OUT_MIN = 20'sh80000;

  // one wheel's ratio job entering the divider
  typedef struct packed {
    logic [32:0] dividend;
    logic [16:0] den;
    logic        force_val;
    logic        force_one;
  } mwm_lane_t;

  // per-lane divider state between stages
  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] q;
    logic [15:0] lo;
    logic [16:0] den;
    logic        force_val;
    logic        force_one;
  } mwm_dstate_t;

  typedef struct packed {
    logic [15:0] q;
    logic        force_val;
    logic        force_one;
  } mwm_quot_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic signed [16:0] ta;
    logic signed [16:0] tb;
    logic signed [32:0] w;
  } mwm_side_t;

  // four restoring divide steps; returns {remainder, quotient bits}
  function automatic logic [20:0] div_step4(input logic [16:0] rem, input logic [3:0] bits,
                                            input logic [16:0] den);
    logic [17:0] t;
    logic [16:0] r;
    logic [3:0]  q;
    r = rem;
    q = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        q[i] = 1'b1;
      end
      r = t[16:0];
    end
    return {r, q};
  endfunction

endpackage

// ===== hdl/mwm_front.sv =====
// Front end: input register, shares and rotation product, then per-wheel
// ratio set-up for the divider. Depends on mwm_pkg.
module mwm_front (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       spin_in,
  input  logic signed [15:0]         vel_forward,
  input  logic signed [15:0]         vel_right,
  input  logic signed [15:0]         yaw_rate,
  input  logic [15:0]                wheel_scale,
  input  logic [15:0]                turn_radius,
  input  logic [14:0]                max_speed,
  output mwm_pkg::mwm_lane_t [3:0]   lanes,
  output mwm_pkg::mwm_side_t         side
);
  import mwm_pkg::*;

  logic               spin1, spin2;
  logic signed [15:0] vf1, vr1, wz1;
  logic signed [16:0] ta2, tb2;
  logic signed [32:0] w2;
  mwm_lane_t [3:0]    lanes_next;

  always_ff @(posedge clk) begin
    if (en) begin
      spin1 <= spin_in;
      vf1   <= vel_forward;
      vr1   <= vel_right;
      wz1   <= yaw_rate;
      spin2 <= spin1;
      ta2   <= 17'(vf1) + 17'(vr1);
      tb2   <= 17'(vf1) - 17'(vr1);
      w2    <= $signed({1'b0, turn_radius}) * wz1;
      lanes <= lanes_next;
      side  <= '{ta: ta2, tb: tb2, w: w2};
    end
  end

  // wheel scale cancels out of the ratio; limit becomes max_speed << 14
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic signed [16:0] t;
    logic signed [34:0] rot, num, lim;
    logic [16:0]        den;
    logic               bounded;
    always_comb begin
      t   = (l == 0 || l == 3) ? ta2 : tb2;
      rot = (l == 0 || l == 2) ? 35'(w2) : -35'(w2);
      lim = $signed({6'd0, max_speed, 14'd0});
      num = t[16] ? lim + rot : lim - rot;
      den = t[16] ? 17'(-t) : 17'(t);
      bounded = spin2 && (wheel_scale != 16'd0) && (t != 17'sd0);
      lanes_next[l].dividend  = {num[30:0], 2'b00};
      lanes_next[l].den       = den;
      lanes_next[l].force_val = 1'b1;
      lanes_next[l].force_one = 1'b1;
      if (bounded) begin
        if (num[34] || num == 35'sd0) begin
          lanes_next[l].force_one = 1'b0;
        end else if (num < $signed({4'd0, den, 14'd0})) begin
          lanes_next[l].force_val = 1'b0;
        end
      end
    end
  end

endmodule

// ===== hdl/mwm_div.sv =====
// Four-lane pipelined restoring divider, four quotient bits per stage,
// with the side data delayed to match. Depends on mwm_pkg.
module mwm_div (
  input  logic                       clk,
  input  logic                       en,
  input  mwm_pkg::mwm_lane_t [3:0]   lanes,
  input  mwm_pkg::mwm_side_t         side_in,
  output mwm_pkg::mwm_quot_t [3:0]   quot,
  output mwm_pkg::mwm_side_t         side_out
);
  import mwm_pkg::*;

  localparam int STAGES = 4;

  mwm_dstate_t [3:0] st [STAGES];
  mwm_dstate_t [3:0] st_next [STAGES];
  mwm_side_t         sd [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    for (genvar l = 0; l < 4; l++) begin : g_lane
      mwm_dstate_t src;
      logic [20:0] step;
      if (j == 0) begin : g_load
        always_comb begin
          src.rem       = lanes[l].dividend[32:16];
          src.q         = 16'd0;
          src.lo        = lanes[l].dividend[15:0];
          src.den       = lanes[l].den;
          src.force_val = lanes[l].force_val;
          src.force_one = lanes[l].force_one;
        end
      end else begin : g_chain
        assign src = st[j-1][l];
      end
      always_comb begin
        step = div_step4(src.rem, src.lo[15:12], src.den);
        st_next[j][l]     = src;
        st_next[j][l].rem = step[20:4];
        st_next[j][l].q   = {src.q[11:0], step[3:0]};
        st_next[j][l].lo  = {src.lo[11:0], 4'd0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= st_next[j];
      end
    end

    if (j == 0) begin : g_side_in
      always_ff @(posedge clk) begin
        if (en) begin
          sd[j] <= side_in;
        end
      end
    end else begin : g_side_pass
      always_ff @(posedge clk) begin
        if (en) begin
          sd[j] <= sd[j-1];
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_out
    assign quot[l] = '{q: st[STAGES-1][l].q, force_val: st[STAGES-1][l].force_val,
                       force_one: st[STAGES-1][l].force_one};
  end
  assign side_out = sd[STAGES-1];

endmodule

// ===== hdl/mwm_back.sv =====
// Back end: least ratio, mix of rotation and scaled translation, split
// multiply by wheel scale, rounding and saturation. Depends on mwm_pkg.
module mwm_back (
  input  logic                       clk,
  input  logic                       en,
  input  mwm_pkg::mwm_quot_t [3:0]   quot,
  input  mwm_pkg::mwm_side_t         side,
  input  logic [15:0]                wheel_scale,
  output logic signed [19:0]         wheel [4],
  output logic [16:0]                shrink_factor
);
  import mwm_pkg::*;

  logic [16:0]        r [4];
  logic [16:0]        s_min;
  logic [16:0]        s1, s2, s3;
  mwm_side_t          sd1;
  logic signed [35:0] x2 [4];
  logic signed [34:0] ph3 [4];
  logic [33:0]        pl3 [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      r[l] = quot[l].force_val ? (quot[l].force_one ? ONE_Q16 : 17'd0)
                               : {1'b0, quot[l].q};
    end
    s_min = r[0];
    for (int l = 1; l < 4; l++) begin
      if (r[l] < s_min) s_min = r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s_min;
      sd1 <= side;
      s2  <= s1;
      s3  <= s2;
      shrink_factor <= s3;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic signed [16:0] t;
    logic signed [35:0] rot4, x_next;
    logic signed [52:0] tot;
    logic signed [24:0] y;
    always_comb begin
      t      = (l == 0 || l == 3) ? sd1.ta : sd1.tb;
      rot4   = {sd1.w[32], sd1.w, 2'b00};
      x_next = ((l == 0 || l == 2) ? rot4 : -rot4) + 36'($signed({1'b0, s1}) * t);
      tot    = (53'(ph3[l]) <<< 18) + $signed({19'd0, pl3[l]}) + 53'sd134217728;
      y      = tot[52:28];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x2[l]  <= x_next;
        ph3[l] <= $signed(x2[l][35:18]) * $signed({1'b0, wheel_scale});
        pl3[l] <= x2[l][17:0] * wheel_scale;
        if (y[24:19] == {6{y[19]}}) begin
          wheel[l] <= y[19:0];
        end else begin
          wheel[l] <= y[24] ? OUT_MIN : OUT_MAX;
        end
      end
    end
  end

endmodule

// ===== hdl/mecanum_wheel_speed_mixer_unit.sv =====
// Mecanum wheel speed mixer, top level: stream ports, configuration
// registers and valid tracking. Depends on mwm_pkg, mwm_front, mwm_div, mwm_back.
//
// Takes one chassis command word per clock and returns one word of four wheel
// targets plus the applied translation scale per command, in order. The path
// from input acceptance to output valid holds three front stages, four
// divider stages (four quotient bits each) and four mixing stages. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so throughput is one word per cycle while the sink keeps up.
// Configuration writes take effect immediately and should be made while idle.
module mecanum_wheel_speed_mixer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // vel_forward [15:0], vel_right [31:16], yaw_rate [47:32]
  input  logic [47:0]                       s_tdata,
  // command [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // front_left [19:0], front_right [39:20], rear_left [59:40],
  // rear_right [79:60], shrink_factor [96:80], zero fill
  output logic [103:0]                      m_tdata,
  input  logic                              cfg_wen,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mwm_pkg::*;

  localparam int DEPTH = 11;

  logic [15:0]        wheel_scale, turn_radius;
  logic [14:0]        max_speed;
  logic               advance;
  logic [DEPTH-1:0]   vld;
  mwm_lane_t [3:0]    lanes;
  mwm_side_t          side_f, side_d;
  mwm_quot_t [3:0]    quot;
  logic signed [19:0] wheel [4];
  logic [16:0]        shrink_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_scale <= WHEEL_SCALE_RST;
      turn_radius <= ROT_RADIUS_RST;
      max_speed   <= MAX_SPEED_RST;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_WHEEL_SCALE: wheel_scale <= cfg_wdata;
        REG_TURN_RADIUS: turn_radius <= cfg_wdata;
        REG_MAX_SPEED:   max_speed   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign advance  = !vld[DEPTH-1] || m_tready;
  assign s_tready = advance;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  mwm_front u_front (
    .clk         (clk),
    .en          (advance),
    .spin_in     (s_tuser),
    .vel_forward (s_tdata[15:0]),
    .vel_right   (s_tdata[31:16]),
    .yaw_rate    (s_tdata[47:32]),
    .wheel_scale (wheel_scale),
    .turn_radius (turn_radius),
    .max_speed   (max_speed),
    .lanes       (lanes),
    .side        (side_f)
  );

  mwm_div u_div (
    .clk      (clk),
    .en       (advance),
    .lanes    (lanes),
    .side_in  (side_f),
    .quot     (quot),
    .side_out (side_d)
  );

  mwm_back u_back (
    .clk           (clk),
    .en            (advance),
    .quot          (quot),
    .side          (side_d),
    .wheel_scale   (wheel_scale),
    .wheel         (wheel),
    .shrink_factor (shrink_factor)
  );

  assign m_tdata = {7'd0, shrink_factor, wheel[3], wheel[2], wheel[1], wheel[0]};

endmodule
